>>> src/sample_fifo_with_window_rms_defines.svh
// Assertion macros for the sample FIFO with window RMS.
// Used by the port checker; needs clk_i and rst_ni in the calling scope.
`ifndef SAMPLE_FIFO_WITH_WINDOW_RMS_DEFINES_SVH
`define SAMPLE_FIFO_WITH_WINDOW_RMS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sfr_pkg.sv
// Shared types and constants for the sample FIFO with window RMS.
// No dependencies.
package sfr_pkg;

  localparam int unsigned SFR_DEPTH       = 64;
  localparam int unsigned SFR_SAMPLE_BITS = 16;

  // Item field widths.
  localparam int unsigned OPC_W  = 2;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned RMS_W  = 24;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FILL_W = 7;

  // RMS arithmetic: the sum saturates at DEPTH * 2^32, the root runs on
  // the sum times 2^16.
  localparam int unsigned CAP_SHIFT  = 32;
  localparam int unsigned FRAC_SHIFT = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_QUERY = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDATA,
    S_WALK,
    S_WAIT_RMS,
    S_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    R_IDLE,
    R_ACC,
    R_FIN,
    R_SQRT
  } rms_state_e;

  typedef struct packed {
    logic start;
    logic smp_vld;
    logic smp_last;
  } rms_ctl_t;

  typedef struct packed {
    logic             done;
    logic [RMS_W-1:0] value;
  } rms_sts_t;

endpackage

>>> src/sfr_if.sv
// Valid/ready channel interfaces for the sample FIFO with window RMS.
// Depends on sfr_pkg.
interface sfr_in_if import sfr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic signed [SMP_W-1:0] write_sample;

  modport source (output valid, opcode, write_sample, input ready);
  modport sink   (input valid, opcode, write_sample, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] read_sample;
  logic [RMS_W-1:0]        rms_value;
  logic [STAT_W-1:0]       status;
  logic [FILL_W-1:0]       fill_count;
  logic                    is_full;
  logic                    is_empty;

  modport source (output valid, read_sample, rms_value, status, fill_count, is_full,
                  is_empty, input ready);
  modport sink   (input valid, read_sample, rms_value, status, fill_count, is_full,
                  is_empty, output ready);
endinterface

>>> src/sample_fifo_with_window_rms.sv
// Sample FIFO with window RMS: top level, control FSM and result register.
// Depends on sfr_pkg, sfr_if, sfr_store and sfr_rms.
//
// in_i carries one item per handshake: an opcode (write, read, RMS query)
// and a sample. out_o returns exactly one result item per input item, in
// order, with the read sample, the RMS, a status code and the fill count
// and full/empty flags as they stand after the operation.
// Write, failed read and unused opcode go from accept straight to the
// result stage; a good read first takes the store's registered read
// data in S_RDATA. A query walks every slot through the single store
// read port, then runs a one-bit-per-cycle square root whose trials
// carry the DEPTH factor in place of a divide; a saturated sum skips
// the root and gives an all-ones RMS. After reset a clearing pass over
// every slot zeroes the store; in_i stays not ready until it ends. The
// result register decouples the sides: when out_o stalls, the next item
// is still accepted and worked on, and its result waits in the pending
// stage until the register is taken.
module sample_fifo_with_window_rms import sfr_pkg::*; #(
  parameter int unsigned DEPTH       = SFR_DEPTH,
  parameter int unsigned SAMPLE_BITS = SFR_SAMPLE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfr_in_if.sink    in_i,
  sfr_out_if.source out_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ctrl_state_e state_q, state_d;

  // FIFO pointers and slot walk / clear index.
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d, idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Read data valid, aligned with the store's registered output.
  logic rd_vld_q, rd_vld_d, rd_last_q, rd_last_d;

  // Pending result, waits for the output register.
  logic [SMP_W-1:0]  pend_rd_q, pend_rd_d;
  logic [RMS_W-1:0]  pend_rms_q, pend_rms_d;
  logic [STAT_W-1:0] pend_st_q, pend_st_d;

  // Output register.
  logic              out_vld_q, out_vld_d;
  logic [SMP_W-1:0]  out_rd_q, out_rd_d;
  logic [RMS_W-1:0]  out_rms_q, out_rms_d;
  logic [STAT_W-1:0] out_st_q, out_st_d;
  logic [FILL_W-1:0] out_fill_q, out_fill_d;
  logic              out_full_q, out_full_d;
  logic              out_empty_q, out_empty_d;

  logic                   in_acc;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;
  logic                   rms_start;
  rms_ctl_t               rms_ctl;
  rms_sts_t               rms_sts;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && (state_q == S_IDLE);

  assign rms_ctl = '{start: rms_start, smp_vld: rd_vld_q, smp_last: rd_last_q};

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_last_d   = 1'b0;
    pend_rd_d   = pend_rd_q;
    pend_rms_d  = pend_rms_q;
    pend_st_d   = pend_st_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_rd_d    = out_rd_q;
    out_rms_d   = out_rms_q;
    out_st_d    = out_st_q;
    out_fill_d  = out_fill_q;
    out_full_d  = out_full_q;
    out_empty_d = out_empty_q;
    mem_we      = 1'b0;
    mem_waddr   = wp_q;
    // Narrow store keeps the low bits; a wider one takes the field as is.
    mem_wdata   = SAMPLE_BITS'($unsigned(in_i.write_sample));
    mem_raddr   = rp_q;
    rms_start   = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = '0;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          pend_rd_d  = '0;
          pend_rms_d = '0;
          pend_st_d  = ST_OK;
          state_d    = S_EMIT;
          case (in_i.opcode)
            OP_WRITE: begin
              if (cnt_q == FULL_CNT) begin
                pend_st_d = ST_FULL;
              end else begin
                mem_we = 1'b1;
                wp_d   = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
                cnt_d  = cnt_q + 1'b1;
              end
            end
            OP_READ: begin
              if (cnt_q == '0) begin
                pend_rd_d = '1;
                pend_st_d = ST_EMPTY;
              end else begin
                // mem_raddr already points at rp_q; data lands next cycle.
                rp_d    = (rp_q == LAST_IDX) ? '0 : rp_q + 1'b1;
                cnt_d   = cnt_q - 1'b1;
                state_d = S_RDATA;
              end
            end
            OP_QUERY: begin
              rms_start = 1'b1;
              idx_d     = '0;
              state_d   = S_WALK;
            end
            default: begin
            end
          endcase
        end
      end

      S_RDATA: begin
        pend_rd_d = SMP_W'($signed(mem_rdata));
        state_d   = S_EMIT;
      end

      // Every slot, queued or not, goes to the RMS unit.
      S_WALK: begin
        mem_raddr = idx_q;
        rd_vld_d  = 1'b1;
        rd_last_d = (idx_q == LAST_IDX);
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_WAIT_RMS;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_WAIT_RMS: begin
        if (rms_sts.done) begin
          pend_rms_d = rms_sts.value;
          state_d    = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d   = 1'b1;
          out_rd_d    = pend_rd_q;
          out_rms_d   = pend_rms_q;
          out_st_d    = pend_st_q;
          out_fill_d  = FILL_W'(cnt_q);
          out_full_d  = (cnt_q == FULL_CNT);
          out_empty_d = (cnt_q == '0);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      wp_q      <= '0;
      rp_q      <= '0;
      idx_q     <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_rd_q   <= pend_rd_d;
    pend_rms_q  <= pend_rms_d;
    pend_st_q   <= pend_st_d;
    out_rd_q    <= out_rd_d;
    out_rms_q   <= out_rms_d;
    out_st_q    <= out_st_d;
    out_fill_q  <= out_fill_d;
    out_full_q  <= out_full_d;
    out_empty_q <= out_empty_d;
  end

  // Items are handled one at a time, so a write never overlaps a read of
  // the same slot: no forwarding path is needed.
  sfr_store #(
    .DEPTH      (DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  sfr_rms #(
    .DEPTH      (DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_rms (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (rms_ctl),
    .smp_i (mem_rdata),
    .sts_o (rms_sts)
  );

  assign out_o.valid       = out_vld_q;
  assign out_o.read_sample = out_rd_q;
  assign out_o.rms_value   = out_rms_q;
  assign out_o.status      = out_st_q;
  assign out_o.fill_count  = out_fill_q;
  assign out_o.is_full     = out_full_q;
  assign out_o.is_empty    = out_empty_q;

endmodule

>>> src/sfr_store.sv
// Sample store: single write port, single read port, registered read data.
// Depends on sfr_pkg.
module sfr_store import sfr_pkg::*; #(
  parameter int unsigned DEPTH       = SFR_DEPTH,
  parameter int unsigned SAMPLE_BITS = SFR_SAMPLE_BITS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [SAMPLE_BITS-1:0]   wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [SAMPLE_BITS-1:0]   rdata_o
);

  logic [SAMPLE_BITS-1:0] mem_q [DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sfr_rms.sv
// RMS unit: squares a stream of samples, saturating sum, then a bit-pair
// square root with trials scaled by the depth. Depends on sfr_pkg.
module sfr_rms import sfr_pkg::*; #(
  parameter int unsigned DEPTH       = SFR_DEPTH,
  parameter int unsigned SAMPLE_BITS = SFR_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rms_ctl_t               ctl_i,
  input  logic [SAMPLE_BITS-1:0] smp_i,
  output rms_sts_t               sts_o
);

  localparam int unsigned LOGD   = $clog2(DEPTH);
  localparam int unsigned SUM_W  = LOGD + CAP_SHIFT + 1;
  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_W  = ((SUM_W > SQ_W) ? SUM_W : SQ_W) + 1;
  localparam int unsigned NUM_W  = SUM_W + FRAC_SHIFT;
  localparam int unsigned RCNT_W = $clog2(RMS_W);

  localparam logic [ACC_W-1:0]  CAP      = ACC_W'(DEPTH) << CAP_SHIFT;
  // First trial, DEPTH * 4^(RMS_W-1).
  localparam logic [NUM_W-1:0]  BIT_INIT = NUM_W'(DEPTH) << (2 * (RMS_W - 1));
  localparam logic [RCNT_W-1:0] RCNT_TOP = RCNT_W'(RMS_W - 1);

  rms_state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq_full, sq_q;
  logic                   sq_vld_q, sq_last_q;
  logic [ACC_W-1:0]       sum_q, sum_d, sum_add, sum_sat;

  logic [NUM_W-1:0]  x_q, x_d, x_step;
  logic [NUM_W-1:0]  res_q, res_d, res_step;
  logic [NUM_W-1:0]  bit_q, bit_d;
  logic [NUM_W:0]    trial;
  logic              take;
  logic [RMS_W-1:0]  root_q, root_d;
  logic [RCNT_W-1:0] rcnt_q, rcnt_d;

  logic [RMS_W-1:0] rms_q, rms_d;
  logic             done_q, done_d;

  // Stage 1: magnitude squared.
  assign mag     = smp_i[SAMPLE_BITS-1] ? (~smp_i + 1'b1) : smp_i;
  assign sq_full = mag * mag;

  // Stage 2: saturating accumulate against DEPTH * 2^32.
  assign sum_add = sum_q + ACC_W'(sq_q);
  assign sum_sat = (sum_add >= CAP) ? CAP : sum_add;

  // One root bit per cycle. r*r <= x/DEPTH exactly when DEPTH*r*r <= x, so
  // the trial and partial root carry the DEPTH factor and no divide is
  // needed; the root bits themselves are shifted into root_q.
  assign trial    = {1'b0, res_q} + {1'b0, bit_q};
  assign take     = {1'b0, x_q} >= trial;
  assign x_step   = take ? (x_q - NUM_W'(trial)) : x_q;
  assign res_step = take ? ((res_q >> 1) + bit_q) : (res_q >> 1);

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    x_d     = x_q;
    res_d   = res_q;
    bit_d   = bit_q;
    root_d  = root_q;
    rcnt_d  = rcnt_q;
    rms_d   = rms_q;
    done_d  = 1'b0;
    case (state_q)
      R_IDLE: begin
      end
      R_ACC: begin
        if (sq_vld_q) begin
          sum_d = sum_sat;
          if (sq_last_q) begin
            state_d = R_FIN;
          end
        end
      end
      R_FIN: begin
        if (sum_q >= CAP) begin
          rms_d   = '1;
          done_d  = 1'b1;
          state_d = R_IDLE;
        end else begin
          x_d     = {sum_q[SUM_W-1:0], {FRAC_SHIFT{1'b0}}};
          res_d   = '0;
          bit_d   = BIT_INIT;
          root_d  = '0;
          rcnt_d  = RCNT_TOP;
          state_d = R_SQRT;
        end
      end
      R_SQRT: begin
        x_d    = x_step;
        res_d  = res_step;
        bit_d  = bit_q >> 2;
        root_d = {root_q[RMS_W-2:0], take};
        rcnt_d = rcnt_q - 1'b1;
        if (rcnt_q == '0) begin
          rms_d   = {root_q[RMS_W-2:0], take};
          done_d  = 1'b1;
          state_d = R_IDLE;
        end
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
    if (ctl_i.start) begin
      sum_d   = '0;
      state_d = R_ACC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= R_IDLE;
      sq_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sq_vld_q <= ctl_i.smp_vld;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q      <= sq_full;
    sq_last_q <= ctl_i.smp_last;
    sum_q     <= sum_d;
    x_q       <= x_d;
    res_q     <= res_d;
    bit_q     <= bit_d;
    root_q    <= root_d;
    rcnt_q    <= rcnt_d;
    rms_q     <= rms_d;
  end

  assign sts_o = '{done: done_q, value: rms_q};

endmodule

>>> src/sfr_checker.sv
// Port-level checker for the sample FIFO with window RMS, and its bind.
// Depends on sfr_pkg and sample_fifo_with_window_rms_defines.svh.
`include "sample_fifo_with_window_rms_defines.svh"

module sfr_port_checker import sfr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [SMP_W-1:0]  read_sample_i,
  input logic [RMS_W-1:0]  rms_value_i,
  input logic [STAT_W-1:0] status_i,
  input logic [FILL_W-1:0] fill_count_i,
  input logic              is_full_i,
  input logic              is_empty_i
);

  logic [SMP_W+RMS_W+STAT_W+FILL_W+1:0] result_bus;
  logic                                 stalled;
  logic                                 drop_seen;
  logic                                 drop_ok;
  logic                                 empty_seen;
  logic                                 empty_ok;

  assign result_bus = {read_sample_i, rms_value_i, status_i, fill_count_i,
                       is_full_i, is_empty_i};
  assign stalled    = out_valid_i && !out_ready_i;
  assign drop_seen  = out_valid_i && (status_i == ST_FULL);
  assign drop_ok    = is_full_i && (read_sample_i == '0) && (rms_value_i == '0);
  assign empty_seen = out_valid_i && (status_i == ST_EMPTY);
  assign empty_ok   = is_empty_i && (read_sample_i == '1) && (rms_value_i == '0);

  `SFR_ASSERT_IMPL(a_flags_excl, out_valid_i, !(is_full_i && is_empty_i), "full and empty")

  `SFR_ASSERT_IMPL(a_full_drop, drop_seen, drop_ok, "dropped write without full FIFO")

  `SFR_ASSERT_IMPL(a_empty_read, empty_seen, empty_ok, "empty read result malformed")

  `SFR_ASSERT_NEXT(a_out_hold, stalled, out_valid_i && $stable(result_bus), "stalled result changed")

endmodule

bind sample_fifo_with_window_rms sfr_port_checker u_sfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .read_sample_i(out_o.read_sample),
  .rms_value_i  (out_o.rms_value),
  .status_i     (out_o.status),
  .fill_count_i (out_o.fill_count),
  .is_full_i    (out_o.is_full),
  .is_empty_i   (out_o.is_empty)
);
